// File: rtl/core/sc2a_pkg.sv
package sc2a_pkg;

    localparam int unsigned CodeW  = 8;
    localparam int unsigned CharW  = 7;
    localparam int unsigned IndexW = 6;

    localparam logic [CodeW-1:0] CODE_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CodeW-1:0] CODE_LSHIFT_BREAK = 8'hAA;
    localparam logic [CodeW-1:0] CODE_RSHIFT_MAKE  = 8'h36;
    localparam logic [CodeW-1:0] CODE_RSHIFT_BREAK = 8'hB6;
    localparam logic [CodeW-1:0] CODE_CAPS_MAKE    = 8'h3A;
    localparam logic [CodeW-1:0] CODE_BREAK_BIT    = 8'h80;
    localparam logic [CodeW-1:0] MAP_LEN           = 8'd58;
    localparam logic [CharW-1:0] CASE_OFFSET       = 7'd32;
    localparam logic [CharW-1:0] CHAR_NONE         = 7'h00;

    typedef struct packed {
        logic lshift;
        logic rshift;
        logic caps;
    } mod_flags_t;

    function automatic logic is_lower(input logic [CharW-1:0] ch);
        return (ch >= 7'h61) && (ch <= 7'h7A);
    endfunction

    function automatic logic is_upper(input logic [CharW-1:0] ch);
        return (ch >= 7'h41) && (ch <= 7'h5A);
    endfunction

    // US layout, unshifted
    function automatic logic [CharW-1:0] plain_map(input logic [IndexW-1:0] idx);
        logic [CharW-1:0] ch;
        case (idx)
            6'd1:    ch = 7'h1B;
            6'd2:    ch = 7'h31;
            6'd3:    ch = 7'h32;
            6'd4:    ch = 7'h33;
            6'd5:    ch = 7'h34;
            6'd6:    ch = 7'h35;
            6'd7:    ch = 7'h36;
            6'd8:    ch = 7'h37;
            6'd9:    ch = 7'h38;
            6'd10:   ch = 7'h39;
            6'd11:   ch = 7'h30;
            6'd12:   ch = 7'h2D;
            6'd13:   ch = 7'h3D;
            6'd14:   ch = 7'h08;
            6'd15:   ch = 7'h09;
            6'd16:   ch = 7'h71;
            6'd17:   ch = 7'h77;
            6'd18:   ch = 7'h65;
            6'd19:   ch = 7'h72;
            6'd20:   ch = 7'h74;
            6'd21:   ch = 7'h79;
            6'd22:   ch = 7'h75;
            6'd23:   ch = 7'h69;
            6'd24:   ch = 7'h6F;
            6'd25:   ch = 7'h70;
            6'd26:   ch = 7'h5B;
            6'd27:   ch = 7'h5D;
            6'd28:   ch = 7'h0A;
            6'd30:   ch = 7'h61;
            6'd31:   ch = 7'h73;
            6'd32:   ch = 7'h64;
            6'd33:   ch = 7'h66;
            6'd34:   ch = 7'h67;
            6'd35:   ch = 7'h68;
            6'd36:   ch = 7'h6A;
            6'd37:   ch = 7'h6B;
            6'd38:   ch = 7'h6C;
            6'd39:   ch = 7'h3B;
            6'd40:   ch = 7'h27;
            6'd41:   ch = 7'h60;
            6'd43:   ch = 7'h5C;
            6'd44:   ch = 7'h7A;
            6'd45:   ch = 7'h78;
            6'd46:   ch = 7'h63;
            6'd47:   ch = 7'h76;
            6'd48:   ch = 7'h62;
            6'd49:   ch = 7'h6E;
            6'd50:   ch = 7'h6D;
            6'd51:   ch = 7'h2C;
            6'd52:   ch = 7'h2E;
            6'd53:   ch = 7'h2F;
            6'd55:   ch = 7'h2A;
            6'd57:   ch = 7'h20;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    // US layout with shift: symbols differ, letters go upper case
    function automatic logic [CharW-1:0] shift_map(input logic [IndexW-1:0] idx);
        logic [CharW-1:0] base;
        logic [CharW-1:0] ch;
        base = plain_map(idx);
        case (idx)
            6'd2:    ch = 7'h21;
            6'd3:    ch = 7'h40;
            6'd4:    ch = 7'h23;
            6'd5:    ch = 7'h24;
            6'd6:    ch = 7'h25;
            6'd7:    ch = 7'h5E;
            6'd8:    ch = 7'h26;
            6'd9:    ch = 7'h2A;
            6'd10:   ch = 7'h28;
            6'd11:   ch = 7'h29;
            6'd12:   ch = 7'h5F;
            6'd13:   ch = 7'h2B;
            6'd26:   ch = 7'h7B;
            6'd27:   ch = 7'h7D;
            6'd39:   ch = 7'h3A;
            6'd40:   ch = 7'h22;
            6'd41:   ch = 7'h7E;
            6'd43:   ch = 7'h7C;
            6'd51:   ch = 7'h3C;
            6'd52:   ch = 7'h3E;
            6'd53:   ch = 7'h3F;
            default: ch = is_lower(base) ? (base - CASE_OFFSET) : base;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/sc2a_decode.sv
module sc2a_decode (
    input  logic [sc2a_pkg::CodeW-1:0] code,
    input  sc2a_pkg::mod_flags_t       flags,
    output sc2a_pkg::mod_flags_t       flags_next,
    output logic                       emit,
    output logic [sc2a_pkg::CharW-1:0] ch
);
    import sc2a_pkg::*;

    logic                is_mod;
    logic                mapped;
    logic [CharW-1:0]    looked;

    always_comb
    begin
        flags_next = flags;
        is_mod     = 1'b1;
        case (code)
            CODE_LSHIFT_MAKE:  flags_next.lshift = 1'b1;
            CODE_LSHIFT_BREAK: flags_next.lshift = 1'b0;
            CODE_RSHIFT_MAKE:  flags_next.rshift = 1'b1;
            CODE_RSHIFT_BREAK: flags_next.rshift = 1'b0;
            CODE_CAPS_MAKE:    flags_next.caps   = ~flags.caps;
            default:           is_mod            = 1'b0;
        endcase
    end

    always_comb
    begin
        mapped = ((code & CODE_BREAK_BIT) == '0) && (code < MAP_LEN);
        looked = (flags.lshift || flags.rshift) ? shift_map(code[IndexW-1:0])
                                                 : plain_map(code[IndexW-1:0]);
        ch = looked;
        if (flags.caps)
        begin
            if (is_lower(looked))
                ch = looked - CASE_OFFSET;
            else if (is_upper(looked))
                ch = looked + CASE_OFFSET;
        end
        emit = !is_mod && mapped && (looked != CHAR_NONE);
    end

endmodule

// File: rtl/core/scancode_to_ascii_translator_unit.sv
// Channel  | Direction | Handshake            | Payload
// -------- | --------- | -------------------- | -------------------------------
// input    | in        | in_valid / in_ready  | scan_byte [7:0], one scancode
// result   | out       | out_valid/ out_ready | ascii_char [6:0], one character
//
// One beat per cycle sustained while no result is held; a scancode beat passes the
// input register, then the result register, before its character appears.
// Modifier flags update as the byte leaves the input register, in beat order.
// Reset clears the shift and caps lock flags and both stage valids.
// A held result stalls the input register; in_ready drops only when both are full.
// Bytes that give no character leave no result beat.
module scancode_to_ascii_translator_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sc2a_pkg::CodeW-1:0] scan_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sc2a_pkg::CharW-1:0] ascii_char
);
    import sc2a_pkg::*;

    logic             s1_valid_reg;
    logic [CodeW-1:0] s1_code_reg;
    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic [CharW-1:0] s2_char_reg;
    mod_flags_t       flags_reg;
    mod_flags_t       flags_next;
    logic             advance;
    logic             emit;
    logic [CharW-1:0] dec_char;

    sc2a_decode u_decode (
        .code       (s1_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .emit       (emit),
        .ch         (dec_char)
    );

    assign advance  = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s2_valid_next = s2_valid_reg && !out_ready;
        if (s1_valid_reg && advance)
            s2_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            s2_valid_reg <= s2_valid_next;
            // commit modifier changes as the byte moves on
            if (s1_valid_reg && advance)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_code_reg <= scan_byte;
        if (s1_valid_reg && advance && emit)
            s2_char_reg <= dec_char;
    end

    assign out_valid  = s2_valid_reg;
    assign ascii_char = s2_char_reg;

endmodule

// File: tb/tb_scancode_to_ascii_translator_unit.sv
`timescale 1ns / 1ps

module tb_scancode_to_ascii_translator_unit;

    import sc2a_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned BEATS_PER_PHASE = 100;

    localparam logic [CodeW-1:0] CODE_CAPS_BREAK = CODE_CAPS_MAKE | CODE_BREAK_BIT;
    localparam logic [CodeW-1:0] CODE_EXT_PREFIX = 8'hE0;

    localparam logic [CharW-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CharW-1:0] CH_LOWER_Z = 7'h7A;
    localparam logic [CharW-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CharW-1:0] CH_UPPER_Z = 7'h5A;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             typed;
        logic             emits;
        logic [CharW-1:0] ch;
    } stim_row_t;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic [CharW-1:0] ch;
    } char_beat_t;

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic [CodeW-1:0] scan_byte  = '0;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    logic [CharW-1:0] ascii_char;

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    mod_flags_t key_mods = '0;
    char_beat_t pending_chars [$];

    // US layout, set 1 make codes 0x00..0x39
    logic [CharW-1:0] us_plain_chars [58] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    logic [CharW-1:0] us_shift_chars [58] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    stim_row_t directed_rows [25] = '{
        '{8'h00,            1'b1, 1'b0, 7'h00},
        '{8'h1E,            1'b1, 1'b1, 7'h61},
        '{8'h01,            1'b1, 1'b1, 7'h1B},
        '{8'h39,            1'b1, 1'b1, 7'h20},
        '{8'h3B,            1'b1, 1'b0, 7'h00},
        '{8'h7F,            1'b1, 1'b0, 7'h00},
        '{8'hFF,            1'b1, 1'b0, 7'h00},
        '{CODE_EXT_PREFIX,  1'b1, 1'b0, 7'h00},
        '{8'h1C,            1'b0, 1'b0, 7'h00},
        '{8'h1D,            1'b0, 1'b0, 7'h00},
        '{CODE_LSHIFT_MAKE, 1'b0, 1'b0, 7'h00},
        '{8'h1E,            1'b0, 1'b0, 7'h00},
        '{8'h02,            1'b0, 1'b0, 7'h00},
        '{CODE_CAPS_MAKE,   1'b0, 1'b0, 7'h00},
        '{8'h1E,            1'b0, 1'b0, 7'h00},
        '{CODE_LSHIFT_BREAK,1'b0, 1'b0, 7'h00},
        '{8'h1E,            1'b0, 1'b0, 7'h00},
        '{CODE_RSHIFT_MAKE, 1'b0, 1'b0, 7'h00},
        '{8'h35,            1'b0, 1'b0, 7'h00},
        '{CODE_CAPS_BREAK,  1'b0, 1'b0, 7'h00},
        '{8'h10,            1'b0, 1'b0, 7'h00},
        '{CODE_RSHIFT_BREAK,1'b0, 1'b0, 7'h00},
        '{CODE_CAPS_MAKE,   1'b0, 1'b0, 7'h00},
        '{8'h9E,            1'b0, 1'b0, 7'h00},
        '{8'h0C,            1'b0, 1'b0, 7'h00}
    };

    scancode_to_ascii_translator_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scan_byte  (scan_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d characters still pending",
                     $time, pending_chars.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Update the modifier flags and work out the character a scancode gives.
    task automatic translate_code(input logic [CodeW-1:0] code, output logic emits,
                                  output logic [CharW-1:0] ch);
        emits = 1'b0;
        ch    = CHAR_NONE;
        case (code)
            CODE_LSHIFT_MAKE:  key_mods.lshift = 1'b1;
            CODE_LSHIFT_BREAK: key_mods.lshift = 1'b0;
            CODE_RSHIFT_MAKE:  key_mods.rshift = 1'b1;
            CODE_RSHIFT_BREAK: key_mods.rshift = 1'b0;
            CODE_CAPS_MAKE:    key_mods.caps   = ~key_mods.caps;
            default:
            begin
                if ((code & CODE_BREAK_BIT) == '0 && code < MAP_LEN)
                begin
                    ch = (key_mods.lshift || key_mods.rshift)
                         ? us_shift_chars[code[IndexW-1:0]]
                         : us_plain_chars[code[IndexW-1:0]];
                    if (key_mods.caps)
                    begin
                        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                            ch = ch - CASE_OFFSET;
                        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
                            ch = ch + CASE_OFFSET;
                    end
                    emits = (ch != CHAR_NONE);
                end
            end
        endcase
    endtask

    // Drive one beat; queue its character once the beat is taken.
    task automatic send_byte(input logic [CodeW-1:0] code, input logic typed,
                             input logic typed_emits, input logic [CharW-1:0] typed_ch);
        logic             emits;
        logic [CharW-1:0] ch;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            scan_byte <= CodeW'($urandom_range(255));
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        scan_byte <= code;
        do
            @(posedge clk);
        while (!in_ready);
        translate_code(code, emits, ch);
        if (typed)
        begin
            emits = typed_emits;
            ch    = typed_ch;
        end
        if (emits)
            pending_chars.push_back('{code: code, ch: ch});
    endtask

    function automatic logic [CodeW-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return CodeW'($urandom_range(MAP_LEN - 1));
        if (r < 55)
            return CODE_BREAK_BIT | CodeW'($urandom_range(MAP_LEN - 1));
        if (r < 70)
        begin
            case ($urandom_range(5))
                0:       return CODE_LSHIFT_MAKE;
                1:       return CODE_LSHIFT_BREAK;
                2:       return CODE_RSHIFT_MAKE;
                3:       return CODE_RSHIFT_BREAK;
                4:       return CODE_CAPS_MAKE;
                default: return CODE_CAPS_BREAK;
            endcase
        end
        if (r < 78)
            return CODE_EXT_PREFIX;
        return CodeW'($urandom_range(255));
    endfunction

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat: expected none, actual ascii_char %h",
                         $time, ascii_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (ascii_char !== want.ch)
                begin
                    error_count++;
                    $display("%0t: ascii_char for scancode %h: expected %h, actual %h",
                             $time, want.code, want.ch, ascii_char);
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].code, directed_rows[i].typed,
                      directed_rows[i].emits, directed_rows[i].ch);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (BEATS_PER_PHASE)
                send_byte(pick_code(), 1'b0, 1'b0, CHAR_NONE);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_decode.sv
rtl/core/scancode_to_ascii_translator_unit.sv
tb/tb_scancode_to_ascii_translator_unit.sv
